// ===== src/dtt_pkg.sv =====
// ----------------------------------------------------------------------------
// dtt_pkg: shared types and constants of the deadline timer table
// Holds the opcode and status codes, the sequencer states and the item
// structs of the input and result channels.
// ----------------------------------------------------------------------------
`default_nettype none

package dtt_pkg;

    // Deadline width: 32-bit timestamp plus 24-bit wait needs one extra bit
    localparam int DL_W = 33;

    // Deadline of an empty table
    localparam logic [DL_W-1:0] DL_MAX = {DL_W{1'b1}};

    typedef enum logic [1:0] {
        OP_START   = 2'd0,
        OP_EXPIRED = 2'd1,
        OP_ALL     = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_STARTED = 2'd0,
        ST_RUNNING = 2'd1,
        ST_FULL    = 2'd2,
        ST_RELEASE = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_INSERT,
        S_EMIT,
        S_POP
    } state_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  client_id;
        logic [23:0] wait_time;
        logic [31:0] now;
    } in_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] released_id;
        logic       has_entry;
        logic       any_ready;
        logic       last;
    } out_item_t;

endpackage

`default_nettype wire

// ===== src/deadline_timer_table_core.sv =====
// ----------------------------------------------------------------------------
// deadline_timer_table_core: sorted table of armed timers
// Keeps client ids with deadlines in deadline order and arms, releases and
// clears them under a small sequencer around one rotating entry ring.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_item carry commands (start, release expired, release
//   all); m_valid/m_ready/m_item carry results, the final one of each
//   command marked by last. The block takes a command only while idle.
//   The table is a ring of entry registers that rotates through its head,
//   so compares on the head entry alone do all searching.
//   Start: after the accept cycle, the id search rotates the ring once
//   through all armed entries, then decides; placement rotates the ring,
//   appends the new entry where the head is later than it or after the
//   last entry, rotates on and closes; then the result is loaded. A start that
//   finds the id armed or the table full skips placement.
//   Release: after the accept cycle, each released entry is shifted out
//   with one result, or one result reports a release that frees nothing.
//   A stalled receiver holds the sequencer in its emit and release states;
//   the block keeps the result register full and waits. Synchronous
//   active-low reset empties the table and drops any pending result.
// ----------------------------------------------------------------------------
`default_nettype none

module deadline_timer_table_core #(
    parameter int TABLE_DEPTH = 16,
    parameter int ID_BITS     = 8
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output      logic               s_ready,
    input  wire dtt_pkg::in_item_t  s_item,
    output      logic               m_valid,
    input  wire logic               m_ready,
    output      dtt_pkg::out_item_t m_item
);

    localparam int ID_W  = (ID_BITS < 8) ? ID_BITS : 8;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int DL_W  = dtt_pkg::DL_W;

    // Sequencer and command registers
    dtt_pkg::state_t    state_reg, state_next;
    logic [1:0]         op_reg, op_next;
    logic [ID_W-1:0]    id_reg, id_next;
    logic [DL_W-1:0]    dl_reg, dl_next;
    logic [DL_W-1:0]    now_reg, now_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   k_reg, k_next;
    logic               match_reg, match_next;
    logic               ins_reg, ins_next;
    dtt_pkg::status_t   status_reg, status_next;

    // Entry ring
    logic [ID_W-1:0]    slot_id_reg   [TABLE_DEPTH];
    logic [ID_W-1:0]    slot_id_next  [TABLE_DEPTH];
    logic [DL_W-1:0]    slot_dl_reg   [TABLE_DEPTH];
    logic [DL_W-1:0]    slot_dl_next  [TABLE_DEPTH];
    logic [ID_W-1:0]    above_id      [TABLE_DEPTH];
    logic [DL_W-1:0]    above_dl      [TABLE_DEPTH];

    // Result register
    logic               m_valid_reg, m_valid_next;
    dtt_pkg::out_item_t m_item_reg, m_item_next;

    // Control
    logic               out_free;
    logic               cnt_zero;
    logic [CNT_W-1:0]   cnt_m1;
    logic [DL_W-1:0]    earliest;
    logic               ready_flag;
    logic               scan_end;
    logic               ins_place;
    logic               ins_end;
    logic               pop_ok;
    logic               pop_last;
    logic               do_rot;
    logic               do_app;
    logic               do_pop;
    logic               load_out;
    dtt_pkg::out_item_t out_val;

    assign s_ready = (state_reg == dtt_pkg::S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // Shared head compares
    assign out_free   = !m_valid_reg || m_ready;
    assign cnt_zero   = (cnt_reg == '0);
    assign cnt_m1     = cnt_reg - 1'b1;
    assign earliest   = cnt_zero ? dtt_pkg::DL_MAX : slot_dl_reg[0];
    assign ready_flag = (earliest < now_reg);
    assign scan_end   = (k_reg == cnt_reg);
    assign ins_place  = !ins_reg && ((k_reg == cnt_reg) || (slot_dl_reg[0] > dl_reg));
    assign ins_end    = ins_reg && (k_reg == cnt_m1);
    assign pop_ok     = !cnt_zero && ((op_reg == dtt_pkg::OP_ALL) ||
                        ((op_reg == dtt_pkg::OP_EXPIRED) && (slot_dl_reg[0] <= now_reg)));
    assign pop_last   = (cnt_reg == CNT_W'(1)) ||
                        ((op_reg == dtt_pkg::OP_EXPIRED) && (slot_dl_reg[1] > now_reg));

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            dtt_pkg::S_IDLE: begin
                if (s_valid) begin
                    state_next = (s_item.op == dtt_pkg::OP_START) ? dtt_pkg::S_SCAN
                                                                  : dtt_pkg::S_POP;
                end
            end
            dtt_pkg::S_SCAN: begin
                if (scan_end) begin
                    if (match_reg || (cnt_reg == CNT_W'(TABLE_DEPTH))) begin
                        state_next = dtt_pkg::S_EMIT;
                    end else begin
                        state_next = dtt_pkg::S_INSERT;
                    end
                end
            end
            dtt_pkg::S_INSERT: begin
                if (ins_end) begin
                    state_next = dtt_pkg::S_EMIT;
                end
            end
            dtt_pkg::S_EMIT: begin
                if (out_free) begin
                    state_next = dtt_pkg::S_IDLE;
                end
            end
            dtt_pkg::S_POP: begin
                if (out_free && (!pop_ok || pop_last)) begin
                    state_next = dtt_pkg::S_IDLE;
                end
            end
            default: state_next = dtt_pkg::S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        op_next     = op_reg;
        id_next     = id_reg;
        dl_next     = dl_reg;
        now_next    = now_reg;
        k_next      = k_reg;
        match_next  = match_reg;
        ins_next    = ins_reg;
        status_next = status_reg;
        do_rot      = 1'b0;
        do_app      = 1'b0;
        do_pop      = 1'b0;
        load_out    = 1'b0;
        out_val     = '0;
        unique case (state_reg)
            dtt_pkg::S_IDLE: begin
                // Latch the command and clear the pass counters
                op_next    = s_item.op;
                id_next    = s_item.client_id[ID_W-1:0];
                dl_next    = DL_W'(s_item.now) + DL_W'(s_item.wait_time);
                now_next   = DL_W'(s_item.now);
                k_next     = '0;
                match_next = 1'b0;
                ins_next   = 1'b0;
            end
            dtt_pkg::S_SCAN: begin
                // Rotate the ring once, looking for the id at the head
                if (scan_end) begin
                    k_next = '0;
                    if (match_reg) begin
                        status_next = dtt_pkg::ST_RUNNING;
                    end else if (cnt_reg == CNT_W'(TABLE_DEPTH)) begin
                        status_next = dtt_pkg::ST_FULL;
                    end else begin
                        status_next = dtt_pkg::ST_STARTED;
                    end
                end else begin
                    do_rot     = 1'b1;
                    k_next     = k_reg + 1'b1;
                    match_next = match_reg || (slot_id_reg[0] == id_reg);
                end
            end
            dtt_pkg::S_INSERT: begin
                // Append the new entry once the head is later than it or the ring is passed, then rotate on
                if (ins_place) begin
                    do_app   = 1'b1;
                    ins_next = 1'b1;
                end else if (!ins_end) begin
                    do_rot = 1'b1;
                    k_next = k_reg + 1'b1;
                end
            end
            dtt_pkg::S_EMIT: begin
                load_out          = out_free;
                out_val.status    = status_reg;
                out_val.any_ready = ready_flag;
                out_val.last      = 1'b1;
            end
            dtt_pkg::S_POP: begin
                // Release the head entry, or report that nothing was released
                load_out       = out_free;
                out_val.status = dtt_pkg::ST_RELEASE;
                if (pop_ok) begin
                    do_pop              = out_free;
                    out_val.released_id = 8'(slot_id_reg[0]);
                    out_val.has_entry   = 1'b1;
                    out_val.last        = pop_last;
                end else begin
                    out_val.any_ready = ready_flag;
                    out_val.last      = 1'b1;
                end
            end
            default: begin
                load_out = 1'b0;
            end
        endcase
    end

    // Entry count
    always_comb begin
        cnt_next = cnt_reg;
        if (do_app) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop) begin
            cnt_next = cnt_m1;
        end
    end

    // Neighbor taps of the ring
    always_comb begin
        for (int i = 0; i < TABLE_DEPTH - 1; i++) begin
            above_id[i] = slot_id_reg[i+1];
            above_dl[i] = slot_dl_reg[i+1];
        end
        above_id[TABLE_DEPTH-1] = slot_id_reg[TABLE_DEPTH-1];
        above_dl[TABLE_DEPTH-1] = slot_dl_reg[TABLE_DEPTH-1];
    end

    // Rotate, append at the tail, or shift out the head
    always_comb begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            slot_id_next[i] = slot_id_reg[i];
            slot_dl_next[i] = slot_dl_reg[i];
            if (do_pop || (do_rot && (CNT_W'(i) < cnt_m1))) begin
                slot_id_next[i] = above_id[i];
                slot_dl_next[i] = above_dl[i];
            end else if (do_rot && (CNT_W'(i) == cnt_m1)) begin
                slot_id_next[i] = slot_id_reg[0];
                slot_dl_next[i] = slot_dl_reg[0];
            end else if (do_app && (CNT_W'(i) == cnt_reg)) begin
                slot_id_next[i] = id_reg;
                slot_dl_next[i] = dl_reg;
            end
        end
    end

    // Result register
    always_comb begin
        m_valid_next = m_valid_reg;
        m_item_next  = m_item_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
            m_item_next  = out_val;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= dtt_pkg::S_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        id_reg     <= id_next;
        dl_reg     <= dl_next;
        now_reg    <= now_next;
        k_reg      <= k_next;
        match_reg  <= match_next;
        ins_reg    <= ins_next;
        status_reg <= status_next;
        m_item_reg <= m_item_next;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            slot_id_reg[i] <= slot_id_next[i];
            slot_dl_reg[i] <= slot_dl_next[i];
        end
    end

endmodule

`default_nettype wire
